// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, checked at every edge including reset.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Concurrent assertion, disabled while rst is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== sv/vslerp_pkg.sv =====
// Shared types and constants for the vector slerp pipeline.
// Holds the CORDIC arctangent table and the Q32 angle and gain constants.
`timescale 1ns / 1ps

package vslerp_pkg;

  localparam int VW = 32;   // vector component width
  localparam int TW = 17;   // fraction width, Q1.16

  localparam logic [TW-1:0] T_ONE = 17'h10000;

  typedef logic signed [VW-1:0] comp_t;

  typedef struct packed {
    comp_t [2:0]     a;
    comp_t [2:0]     b;
    logic [TW-1:0]   t;
    logic            deg;
  } item_t;

  // atan(2^-i) in Q32
  localparam logic [63:0] ATAN_Q32 [32] = '{
    64'd3373259426, 64'd1991351318, 64'd1052175346, 64'd534100635, 64'd268086748,
    64'd134174063, 64'd67103403, 64'd33553749, 64'd16777131, 64'd8388597,
    64'd4194303, 64'd2097152, 64'd1048576, 64'd524288, 64'd262144, 64'd131072,
    64'd65536, 64'd32768, 64'd16384, 64'd8192, 64'd4096, 64'd2048, 64'd1024,
    64'd512, 64'd256, 64'd128, 64'd64, 64'd32, 64'd16, 64'd8, 64'd4, 64'd2
  };

  localparam logic [63:0] HALF_PI_Q32 = 64'd6746518852;
  localparam logic [63:0] PI_Q32      = 64'd13493037705;
  localparam logic [63:0] GAIN_Q32    = 64'd2608131496;

  // Q32 to Q(fb), rounded half up
  function automatic logic [63:0] q32_to_f(logic [63:0] v, int fb);
    q32_to_f = (v + (64'd1 << (31 - fb))) >> (32 - fb);
  endfunction

endpackage

// ===== sv/vslerp_sqrt.sv =====
// Pipelined floor square root, one result bit per stage.
// Uses no package items; side payload travels with each item.
`timescale 1ns / 1ps

module vslerp_sqrt #(
  parameter int W  = 62,
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [W-1:0]     rad,
  input  logic [SW-1:0]    in_side,
  output logic             out_vld,
  output logic [W/2-1:0]   root,
  output logic [SW-1:0]    out_side
);

  localparam int N = W / 2;

  logic [N-1:0]  vld;
  logic [W-1:0]  rq [N];
  logic [W-1:0]  sq [N];
  logic [SW-1:0] dq [N];
  logic [W-1:0]  ri [N];
  logic [W-1:0]  si [N];
  logic [SW-1:0] di [N];
  logic [W-1:0]  rn [N];
  logic [W-1:0]  sn [N];

  always_comb begin
    ri[0] = rad;
    si[0] = '0;
    di[0] = in_side;
    for (int k = 1; k < N; k++) begin
      ri[k] = rq[k-1];
      si[k] = sq[k-1];
      di[k] = dq[k-1];
    end
  end

  always_comb begin
    logic [W-1:0] bitv;
    logic [W-1:0] trial;
    for (int k = 0; k < N; k++) begin
      bitv  = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * k);
      trial = si[k] + bitv;
      if (ri[k] >= trial) begin
        rn[k] = ri[k] - trial;
        sn[k] = (si[k] >> 1) + bitv;
      end else begin
        rn[k] = ri[k];
        sn[k] = si[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rq[k] <= rn[k];
        sq[k] <= sn[k];
        dq[k] <= di[k];
      end
    end
  end

  assign out_vld  = vld[N-1];
  assign root     = sq[N-1][N-1:0];
  assign out_side = dq[N-1];

endmodule

// ===== sv/vslerp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Starts from a given partial remainder; no package items used.
`timescale 1ns / 1ps

module vslerp_div #(
  parameter int DW = 62,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  logic [DW-1:0]  rem0,
  input  logic [QW-1:0]  num,
  input  logic [DW-1:0]  den,
  input  logic [SW-1:0]  in_side,
  output logic           out_vld,
  output logic [QW-1:0]  quo,
  output logic [SW-1:0]  out_side
);

  logic [QW-1:0] vld;
  logic [DW-1:0] rq [QW];
  logic [QW-1:0] nq [QW];
  logic [DW-1:0] dq [QW];
  logic [SW-1:0] sq [QW];
  logic [DW-1:0] ri [QW];
  logic [QW-1:0] ni [QW];
  logic [DW-1:0] di [QW];
  logic [SW-1:0] si [QW];
  logic [DW-1:0] rn [QW];
  logic [QW-1:0] nn [QW];

  always_comb begin
    ri[0] = rem0;
    ni[0] = num;
    di[0] = den;
    si[0] = in_side;
    for (int k = 1; k < QW; k++) begin
      ri[k] = rq[k-1];
      ni[k] = nq[k-1];
      di[k] = dq[k-1];
      si[k] = sq[k-1];
    end
  end

  // numerator bits shift out the top while quotient bits shift in below
  always_comb begin
    logic [DW:0] r2;
    for (int k = 0; k < QW; k++) begin
      r2 = {ri[k], ni[k][QW-1]};
      if (r2 >= {1'b0, di[k]}) begin
        rn[k] = DW'(r2 - {1'b0, di[k]});
        nn[k] = {ni[k][QW-2:0], 1'b1};
      end else begin
        rn[k] = r2[DW-1:0];
        nn[k] = {ni[k][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rq[k] <= rn[k];
        nq[k] <= nn[k];
        dq[k] <= di[k];
        sq[k] <= si[k];
      end
    end
  end

  assign out_vld  = vld[QW-1];
  assign quo      = nq[QW-1];
  assign out_side = sq[QW-1];

endmodule

// ===== sv/vslerp_cordic.sv =====
// Pipelined CORDIC, one micro-rotation per stage, vectoring or rotation.
// Depends on vslerp_pkg for the arctangent table.
`timescale 1ns / 1ps

module vslerp_cordic
  import vslerp_pkg::*;
#(
  parameter int XW   = 20,
  parameter int N    = 20,
  parameter int FB   = 16,
  parameter bit VECT = 1'b0,
  parameter int SW   = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic signed [XW-1:0]  x_in,
  input  logic signed [XW-1:0]  y_in,
  input  logic signed [XW-1:0]  z_in,
  input  logic [SW-1:0]         in_side,
  output logic                  out_vld,
  output logic signed [XW-1:0]  x_out,
  output logic signed [XW-1:0]  y_out,
  output logic signed [XW-1:0]  z_out,
  output logic [SW-1:0]         out_side
);

  logic [N-1:0]         vld;
  logic signed [XW-1:0] xq [N];
  logic signed [XW-1:0] yq [N];
  logic signed [XW-1:0] zq [N];
  logic [SW-1:0]        sq [N];
  logic signed [XW-1:0] xi [N];
  logic signed [XW-1:0] yi [N];
  logic signed [XW-1:0] zi [N];
  logic [SW-1:0]        si [N];
  logic signed [XW-1:0] xn [N];
  logic signed [XW-1:0] yn [N];
  logic signed [XW-1:0] zn [N];

  always_comb begin
    xi[0] = x_in;
    yi[0] = y_in;
    zi[0] = z_in;
    si[0] = in_side;
    for (int k = 1; k < N; k++) begin
      xi[k] = xq[k-1];
      yi[k] = yq[k-1];
      zi[k] = zq[k-1];
      si[k] = sq[k-1];
    end
  end

  // vectoring drives y to zero, rotation drives z to zero
  always_comb begin
    logic signed [XW-1:0] ang;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic                 rot;
    for (int k = 0; k < N; k++) begin
      ang = XW'(q32_to_f(ATAN_Q32[k], FB));
      dx  = yi[k] >>> k;
      dy  = xi[k] >>> k;
      rot = VECT ? (yi[k] > 0) : zi[k][XW-1];
      if (rot) begin
        xn[k] = xi[k] + dx;
        yn[k] = yi[k] - dy;
        zn[k] = zi[k] + ang;
      end else begin
        xn[k] = xi[k] - dx;
        yn[k] = yi[k] + dy;
        zn[k] = zi[k] - ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        xq[k] <= xn[k];
        yq[k] <= yn[k];
        zq[k] <= zn[k];
        sq[k] <= si[k];
      end
    end
  end

  assign out_vld  = vld[N-1];
  assign x_out    = xq[N-1];
  assign y_out    = yq[N-1];
  assign z_out    = zq[N-1];
  assign out_side = sq[N-1];

endmodule

// ===== sv/vector_slerp.sv =====
// vector_slerp: spherical linear interpolation of two Q16.16 3-D vectors.
// Throughput: one beat per cycle; the whole pipeline advances whenever the
//   output register is empty or being taken, so a stall freezes every stage.
// Reset: rst (synchronous, active high) clears all stage valid bits.
`timescale 1ns / 1ps

module vector_slerp
  import vslerp_pkg::*;
#(
  parameter int FRAC_BITS  = 16,
  parameter int ITERATIONS = 20
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // a_x[31:0] a_y[63:32] a_z[95:64] b_x[127:96] b_y[159:128] b_z[191:160]
  // frac[208:192], zero fill above
  input  logic [215:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // res_x[31:0] res_y[63:32] res_z[95:64]
  output logic [95:0]  m_tdata,
  // degenerate[0] saturated[1]
  output logic [1:0]   m_tuser
);

  localparam int F   = FRAC_BITS;
  localparam int AW  = F + 2;            // angle, unsigned, covers pi
  localparam int XW  = F + 4;            // CORDIC datapath
  localparam int SQW = 2 * F + 2;        // radicand of the sine root
  localparam int NW  = 2 * F + 1;        // factor numerator / quotient
  localparam int PW  = VW + F + 2;       // component times factor half
  localparam int VWW = PW + 2;           // combined result before clipping

  localparam logic [63:0] HALF_PI_F = q32_to_f(HALF_PI_Q32, F);
  localparam logic [63:0] PI_F      = q32_to_f(PI_Q32, F);
  localparam logic [63:0] GAIN_F    = q32_to_f(GAIN_Q32, F);
  localparam logic [AW-1:0] HALF_PI_A = AW'(HALF_PI_F);
  localparam logic [AW-1:0] PI_A      = AW'(PI_F);

  typedef struct packed {
    item_t              it;
    logic signed [63:0] dot;
  } s1_t;

  typedef struct packed {
    item_t it;
    logic  neg;
    logic  big;
  } s2_t;

  typedef struct packed {
    item_t      it;
    logic [F:0] q;
    logic       neg;
  } s3_t;

  typedef struct packed {
    item_t      it;
    logic [F:0] s;
  } s4_t;

  // ---------------------------------------------------------------------
  // Global advance: every stage moves when the output slot frees up.
  // ---------------------------------------------------------------------
  logic en;
  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;

  function automatic logic [4:0] msb_pos(logic [31:0] m);
    msb_pos = '0;
    for (int i = 0; i < 32; i++) begin
      if (m[i]) msb_pos = 5'(i);
    end
  endfunction

  // bring the largest magnitude into [2^29, 2^30); right shifts floor
  function automatic comp_t scale_one(comp_t v, logic [4:0] p);
    if (p >= 5'd30) scale_one = v >>> (p - 5'd29);
    else            scale_one = v <<< (5'd29 - p);
  endfunction

  function automatic logic [31:0] mag(comp_t v);
    mag = v[31] ? (~v + 32'd1) : v;
  endfunction

  // Valid bits of the stages owned by this level
  logic v1, v2, v3, v4, v5, v7, v8, v9, v10, v11, v12, v13, v14, v15, v16, v17, v18;

  // ---- p1: capture, clamp fraction ----
  item_t it1;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        it1.a[i] <= s_tdata[32*i +: 32];
        it1.b[i] <= s_tdata[96 + 32*i +: 32];
      end
      it1.t   <= (s_tdata[208:192] > T_ONE) ? T_ONE : s_tdata[208:192];
      it1.deg <= 1'b0;
    end
  end

  // ---- p2: largest magnitude of each vector ----
  item_t       it2;
  logic [31:0] ma2, mb2;
  always_ff @(posedge clk) begin
    logic [31:0] ma, mb;
    if (en) begin
      ma = '0;
      mb = '0;
      for (int i = 0; i < 3; i++) begin
        if (mag(it1.a[i]) > ma) ma = mag(it1.a[i]);
        if (mag(it1.b[i]) > mb) mb = mag(it1.b[i]);
      end
      it2 <= it1;
      ma2 <= ma;
      mb2 <= mb;
    end
  end

  // ---- p3: direction scaling; a zero vector is degenerate ----
  item_t it3;
  comp_t da3 [3];
  comp_t db3 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        da3[i] <= scale_one(it2.a[i], msb_pos(ma2));
        db3[i] <= scale_one(it2.b[i], msb_pos(mb2));
      end
      it3 <= '{a: it2.a, b: it2.b, t: it2.t, deg: (ma2 == '0) || (mb2 == '0)};
    end
  end

  // ---- p4: dot terms and squares ----
  item_t              it4;
  logic signed [63:0] pd4 [3];
  logic signed [63:0] pa4 [3];
  logic signed [63:0] pb4 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pd4[i] <= da3[i] * db3[i];
        pa4[i] <= da3[i] * da3[i];
        pb4[i] <= db3[i] * db3[i];
      end
      it4 <= it3;
    end
  end

  // ---- p5: sums ----
  item_t              it5;
  logic signed [63:0] dot5;
  logic [61:0]        sqa5, sqb5;
  always_ff @(posedge clk) begin
    logic signed [63:0] sa, sb;
    if (en) begin
      sa   = pa4[0] + pa4[1] + pa4[2];
      sb   = pb4[0] + pb4[1] + pb4[2];
      dot5 <= pd4[0] + pd4[1] + pd4[2];
      sqa5 <= sa[61:0];
      sqb5 <= sb[61:0];
      it5  <= it4;
    end
  end

  // ---- norms: two square-root lanes ----
  logic        va6;
  logic [30:0] na6, nb6;
  s1_t         s1_in, sa6;
  assign s1_in.it  = it5;
  assign s1_in.dot = dot5;

  vslerp_sqrt #(.W(62), .SW($bits(s1_t))) u_norm_a (
    .clk(clk), .rst(rst), .en(en), .in_vld(v5), .rad(sqa5), .in_side(s1_in),
    .out_vld(va6), .root(na6), .out_side(sa6)
  );

  vslerp_sqrt #(.W(62), .SW(1)) u_norm_b (
    .clk(clk), .rst(rst), .en(en), .in_vld(v5), .rad(sqb5), .in_side(1'b0),
    .out_vld(), .root(nb6), .out_side()
  );

  // ---- p6: norm product, |dot| ----
  item_t       it7;
  logic [61:0] num7, den7;
  logic        neg7;
  always_ff @(posedge clk) begin
    if (en) begin
      den7 <= na6 * nb6;
      num7 <= sa6.dot[63] ? 62'(-sa6.dot) : sa6.dot[61:0];
      neg7 <= sa6.dot[63];
      it7  <= sa6.it;
    end
  end

  // ---- p7: cosine saturates at one when |dot| reaches the norm product ----
  item_t       it8;
  logic [61:0] num8, den8;
  logic        neg8, big8;
  always_ff @(posedge clk) begin
    if (en) begin
      num8 <= num7;
      den8 <= den7;
      neg8 <= neg7;
      big8 <= num7 >= den7;
      it8  <= it7;
    end
  end

  // ---- cosine quotient |dot| * 2^F / den ----
  logic          vc;
  logic [F-1:0]  quo_c;
  s2_t           s2_in, sc;
  assign s2_in.it  = it8;
  assign s2_in.neg = neg8;
  assign s2_in.big = big8;

  vslerp_div #(.DW(62), .QW(F), .SW($bits(s2_t))) u_cos_div (
    .clk(clk), .rst(rst), .en(en), .in_vld(v8), .rem0(num8), .num('0), .den(den8),
    .in_side(s2_in), .out_vld(vc), .quo(quo_c), .out_side(sc)
  );

  // ---- p8: |c| and c^2 ----
  item_t          it9;
  logic [F:0]     q9;
  logic           neg9;
  logic [SQW-1:0] cc9;
  logic [F:0]     qsel;
  assign qsel = sc.big ? ((F+1)'(1) << F) : {1'b0, quo_c};
  always_ff @(posedge clk) begin
    if (en) begin
      q9   <= qsel;
      cc9  <= qsel * qsel;
      neg9 <= sc.neg;
      it9  <= sc.it;
    end
  end

  // ---- p9: 1 - c^2 ----
  s3_t            s3_in;
  logic [SQW-1:0] rad10;
  always_ff @(posedge clk) begin
    if (en) begin
      rad10     <= (SQW'(1) << (2 * F)) - cc9;
      s3_in.it  <= it9;
      s3_in.q   <= q9;
      s3_in.neg <= neg9;
    end
  end

  // ---- sine of the angle ----
  logic       vs;
  logic [F:0] sroot;
  s3_t        ss;

  vslerp_sqrt #(.W(SQW), .SW($bits(s3_t))) u_sin_root (
    .clk(clk), .rst(rst), .en(en), .in_vld(v10), .rad(rad10), .in_side(s3_in),
    .out_vld(vs), .root(sroot), .out_side(ss)
  );

  // ---- p10: vectoring start; negative cosine pre-rotates by pi/2 ----
  logic signed [XW-1:0] x11, y11, z11;
  s4_t                  s11;
  logic                 c_pos;
  assign c_pos = ~ss.neg | (ss.q == '0);
  always_ff @(posedge clk) begin
    if (en) begin
      x11     <= c_pos ? XW'(ss.q) : XW'(sroot);
      y11     <= c_pos ? XW'(sroot) : XW'(ss.q);
      z11     <= c_pos ? '0 : XW'(HALF_PI_F);
      s11     <= '{it: '{a: ss.it.a, b: ss.it.b, t: ss.it.t,
                         deg: ss.it.deg | (sroot == '0)},
                   s: sroot};
    end
  end

  logic                 vv;
  logic signed [XW-1:0] zv;
  s4_t                  sv;

  vslerp_cordic #(.XW(XW), .N(ITERATIONS), .FB(F), .VECT(1'b1), .SW($bits(s4_t)))
  u_atan (
    .clk(clk), .rst(rst), .en(en), .in_vld(v11), .x_in(x11), .y_in(y11), .z_in(z11),
    .in_side(s11), .out_vld(vv), .x_out(), .y_out(), .z_out(zv), .out_side(sv)
  );

  // ---- p11: clamp angle to [0, pi] ----
  logic [AW-1:0] w12;
  s4_t           s12;
  always_ff @(posedge clk) begin
    if (en) begin
      if (zv[XW-1])            w12 <= '0;
      else if (zv > XW'(PI_F)) w12 <= PI_A;
      else                     w12 <= AW'(zv);
      s12 <= sv;
    end
  end

  // ---- p12: w * t ----
  logic [AW-1:0]  w13;
  logic [AW+16:0] wt13;
  s4_t            s13;
  always_ff @(posedge clk) begin
    if (en) begin
      wt13 <= w12 * s12.it.t;
      w13  <= w12;
      s13  <= s12;
    end
  end

  // ---- p13: t*w rounded, (1-t)*w ----
  logic [AW-1:0]  tw14, uw14;
  s4_t            s14;
  logic [AW+16:0] twr;
  assign twr = wt13 + (AW+17)'(32768);
  always_ff @(posedge clk) begin
    if (en) begin
      tw14 <= twr[AW+15:16];
      uw14 <= w13 - twr[AW+15:16];
      s14  <= s13;
    end
  end

  // ---- p14: fold angles above pi/2 ----
  logic signed [XW-1:0] zu15, zt15;
  s4_t                  s15;
  always_ff @(posedge clk) begin
    if (en) begin
      zu15 <= XW'((uw14 > HALF_PI_A) ? (PI_A - uw14) : uw14);
      zt15 <= XW'((tw14 > HALF_PI_A) ? (PI_A - tw14) : tw14);
      s15  <= s14;
    end
  end

  // ---- sines of the two partial angles ----
  logic                 vr;
  logic signed [XW-1:0] yu, yt;
  s4_t                  sr;

  vslerp_cordic #(.XW(XW), .N(ITERATIONS), .FB(F), .VECT(1'b0), .SW($bits(s4_t)))
  u_sin_u (
    .clk(clk), .rst(rst), .en(en), .in_vld(v15), .x_in(XW'(GAIN_F)), .y_in('0),
    .z_in(zu15), .in_side(s15), .out_vld(vr), .x_out(), .y_out(yu), .z_out(),
    .out_side(sr)
  );

  vslerp_cordic #(.XW(XW), .N(ITERATIONS), .FB(F), .VECT(1'b0), .SW(1))
  u_sin_t (
    .clk(clk), .rst(rst), .en(en), .in_vld(v15), .x_in(XW'(GAIN_F)), .y_in('0),
    .z_in(zt15), .in_side(1'b0), .out_vld(), .x_out(), .y_out(yt), .z_out(),
    .out_side()
  );

  // ---- p15: clamp sines, build rounded numerators ----
  logic [NW-1:0] nu16, nt16;
  logic [F:0]    s16;
  item_t         it16;
  logic [F:0]    sin_u, sin_t;
  always_comb begin
    if (yu[XW-1])                 sin_u = '0;
    else if (yu > (XW'(1) << F))  sin_u = (F+1)'(1) << F;
    else                          sin_u = yu[F:0];
    if (yt[XW-1])                 sin_t = '0;
    else if (yt > (XW'(1) << F))  sin_t = (F+1)'(1) << F;
    else                          sin_t = yt[F:0];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nu16 <= {sin_u, {F{1'b0}}} + NW'(sr.s >> 1);
      nt16 <= {sin_t, {F{1'b0}}} + NW'(sr.s >> 1);
      s16  <= sr.s;
      it16 <= sr.it;
    end
  end

  // ---- weights sin(.)/sin(w) ----
  logic          vd;
  logic [NW-1:0] f0, f1;
  item_t         sd;

  vslerp_div #(.DW(F+1), .QW(NW), .SW($bits(item_t))) u_f0_div (
    .clk(clk), .rst(rst), .en(en), .in_vld(v16), .rem0('0), .num(nu16), .den(s16),
    .in_side(it16), .out_vld(vd), .quo(f0), .out_side(sd)
  );

  vslerp_div #(.DW(F+1), .QW(NW), .SW(1)) u_f1_div (
    .clk(clk), .rst(rst), .en(en), .in_vld(v16), .rem0('0), .num(nt16), .den(s16),
    .in_side(1'b0), .out_vld(), .quo(f1), .out_side()
  );

  // ---- p16: component products, weights split into integer and fraction ----
  item_t              it17;
  logic signed [PW-1:0] ph0 [3];
  logic signed [PW-1:0] ph1 [3];
  logic signed [PW-1:0] pl0 [3];
  logic signed [PW-1:0] pl1 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ph0[i] <= sd.a[i] * $signed({1'b0, f0[2*F:F]});
        ph1[i] <= sd.b[i] * $signed({1'b0, f1[2*F:F]});
        pl0[i] <= sd.a[i] * $signed({1'b0, f0[F-1:0]});
        pl1[i] <= sd.b[i] * $signed({1'b0, f1[F-1:0]});
      end
      it17 <= sd;
    end
  end

  // ---- p17: combine, round the fractional part half up ----
  item_t                 it18;
  logic signed [VWW-1:0] r18 [3];
  logic signed [VWW-1:0] lsum [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lsum[i] = VWW'(pl0[i]) + VWW'(pl1[i]) + (VWW'(1) <<< (F - 1));
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r18[i] <= VWW'(ph0[i]) + VWW'(ph1[i]) + (lsum[i] >>> F);
      end
      it18 <= it17;
    end
  end

  // ---- p18: clip to 32 bits; degenerate beats are forced to zero ----
  logic [2:0]  ovf;
  logic [95:0] res;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ovf[i] = ~((&r18[i][VWW-1:31]) | ~(|r18[i][VWW-1:31]));
      if (!ovf[i])           res[32*i +: 32] = r18[i][31:0];
      else if (r18[i][VWW-1]) res[32*i +: 32] = 32'h8000_0000;
      else                   res[32*i +: 32] = 32'h7FFF_FFFF;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata    <= it18.deg ? '0 : res;
      m_tuser[0] <= it18.deg;
      m_tuser[1] <= ~it18.deg & (|ovf);
    end
  end

  // ---- stage valid bits ----
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v7, v8, v9, v10} <= '0;
      {v11, v12, v13, v14, v15, v16, v17, v18, m_tvalid} <= '0;
    end else if (en) begin
      v1       <= s_tvalid;
      v2       <= v1;
      v3       <= v2;
      v4       <= v3;
      v5       <= v4;
      v7       <= va6;
      v8       <= v7;
      v9       <= vc;
      v10      <= v9;
      v11      <= vs;
      v12      <= vv;
      v13      <= v12;
      v14      <= v13;
      v15      <= v14;
      v16      <= vr;
      v17      <= vd;
      v18      <= v17;
      m_tvalid <= v18;
    end
  end

endmodule

// ===== sv/vslerp_checker.sv =====
// Port-level checks for vector_slerp, attached by bind.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vslerp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // degenerate beats carry a zero vector and never the clip flag
  `ASSERT_CLK_RST(a_deg_zero, clk, rst, m_tvalid && m_tuser[0] |-> m_tdata == 96'd0 && !m_tuser[1], "degenerate beat not zero")

  // input side is open whenever the output slot is free or draining
  `ASSERT_CLK_RST(a_ready, clk, rst, !m_tvalid || m_tready |-> s_tready, "input stalled with free output")

  // a stalled result holds
  `ASSERT_CLK_RST(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled beat changed")

  // reset empties the pipeline
  `ASSERT_CLK(a_rst_empty, clk, rst |=> !m_tvalid, "output valid after reset")

endmodule

bind vector_slerp vslerp_checker u_vslerp_checker (.*);

// ===== tb/vector_slerp_tb.sv =====
// Self-checking testbench for vector_slerp: directed table, then random vectors.
// Holds its own fixed-point slerp model; uses vslerp_pkg only for the comp_t component type.
`timescale 1ns / 1ps

module vector_slerp_tb;
  import vslerp_pkg::*;

  localparam int FB = 16;
  localparam int NITER = 20;
  localparam int PIPE_DRAIN = 200;
  localparam int RX_HOLD = 400;       // long receiver hold-off, fills the pipe

  typedef longint vec3_t [3];

  typedef struct {
    comp_t       x, y, z;
    logic        deg;
    logic        sat;
  } slerp_res_t;

  typedef struct {
    comp_t       a [3];
    comp_t       b [3];
    logic [16:0] frac;
    bit          typed;     // row carries a hand-written result
    slerp_res_t  res;
  } slerp_row_t;

  // atan(2^-i) in Q32, plus the angle and gain constants
  localparam longint unsigned ATAN_TAB [32] = '{
    64'd3373259426, 64'd1991351318, 64'd1052175346, 64'd534100635, 64'd268086748,
    64'd134174063, 64'd67103403, 64'd33553749, 64'd16777131, 64'd8388597,
    64'd4194303, 64'd2097152, 64'd1048576, 64'd524288, 64'd262144, 64'd131072,
    64'd65536, 64'd32768, 64'd16384, 64'd8192, 64'd4096, 64'd2048, 64'd1024,
    64'd512, 64'd256, 64'd128, 64'd64, 64'd32, 64'd16, 64'd8, 64'd4, 64'd2
  };
  localparam longint unsigned HPI_Q32  = 64'd6746518852;
  localparam longint unsigned PI_Q32V  = 64'd13493037705;
  localparam longint unsigned GAIN_Q32V = 64'd2608131496;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [215:0] s_tdata;   // a_x a_y a_z b_x b_y b_z (32 each), frac[208:192]
  logic         m_tvalid;
  logic         m_tready;
  logic [95:0]  m_tdata;   // res_x res_y res_z (32 each)
  logic [1:0]   m_tuser;   // degenerate[0] saturated[1]

  slerp_res_t   pending_q [$];   // expected results, oldest first
  int           mismatches = 0;
  int           tx_idle_pct = 18;
  int           rx_idle_pct = 74;
  int           rx_hold_cnt = 0;

  vector_slerp dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  // ---------------- fixed-point slerp model ----------------

  function automatic longint q32f(longint unsigned v);
    return longint'((v + (64'd1 << (31 - FB))) >> (32 - FB));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // normalize so the largest magnitude sits in [2^29, 2^30); 0 for a null vector
  function automatic bit normalize_dir(input vec3_t v, output vec3_t o);
    longint m, mag;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      mag = v[i] < 0 ? -v[i] : v[i];
      if (mag > m) m = mag;
      o[i] = v[i];
    end
    if (m == 0) return 1'b0;
    while (m >= (64'sd1 <<< 30)) begin
      for (int i = 0; i < 3; i++) o[i] = o[i] >>> 1;
      m = m >>> 1;
    end
    while (m < (64'sd1 <<< 29)) begin
      for (int i = 0; i < 3; i++) o[i] = o[i] * 2;
      m = m * 2;
    end
    return 1'b1;
  endfunction

  function automatic longint sine_fx(longint theta);
    longint x, y, z, dx, dy;
    x = q32f(GAIN_Q32V);
    y = 0;
    if (theta > q32f(HPI_Q32)) theta = q32f(PI_Q32V) - theta;
    z = theta;
    for (int i = 0; i < NITER; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= q32f(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += q32f(ATAN_TAB[i]);
      end
    end
    if (y < 0) y = 0;
    if (y > (64'sd1 <<< FB)) y = 64'sd1 <<< FB;
    return y;
  endfunction

  function automatic slerp_res_t slerp_predict(comp_t a_in [3], comp_t b_in [3],
                                              logic [16:0] frac);
    slerp_res_t r;
    vec3_t a, b, da, db;
    longint dot, c, s, w, x, y, z, dx, dy, tw, uw, f0, f1, v, t;
    longint unsigned num, den, q, rem;
    r = '{x: 0, y: 0, z: 0, deg: 1'b1, sat: 1'b0};
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'(a_in[i]);
      b[i] = longint'(b_in[i]);
    end
    t = frac > 17'd65536 ? 65536 : longint'(frac);
    if (!normalize_dir(a, da) || !normalize_dir(b, db)) return r;
    dot = da[0] * db[0] + da[1] * db[1] + da[2] * db[2];
    den = int_sqrt(da[0] * da[0] + da[1] * da[1] + da[2] * da[2]) *
          int_sqrt(db[0] * db[0] + db[1] * db[1] + db[2] * db[2]);
    num = dot < 0 ? -dot : dot;
    q = 0;
    if (num >= den) begin
      q = 64'd1 << FB;
    end else begin
      rem = num;
      for (int k = 0; k < FB; k++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= den) begin
          rem = rem - den;
          q = q | 1;
        end
      end
    end
    c = dot < 0 ? -longint'(q) : longint'(q);
    s = longint'(int_sqrt((64'd1 << (2 * FB)) - longint'(c * c)));
    if (s == 0) return r;
    // vectoring CORDIC gives the angle between the two directions
    if (c >= 0) begin
      x = c; y = s; z = 0;
    end else begin
      x = s; y = -c; z = q32f(HPI_Q32);
    end
    for (int k = 0; k < NITER; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (y > 0) begin
        x += dx; y -= dy; z += q32f(ATAN_TAB[k]);
      end else begin
        x -= dx; y += dy; z -= q32f(ATAN_TAB[k]);
      end
    end
    w = z;
    if (w < 0) w = 0;
    if (w > q32f(PI_Q32V)) w = q32f(PI_Q32V);
    tw = (w * t + 32768) >>> 16;
    uw = w - tw;
    f0 = (sine_fx(uw) * (64'sd1 <<< FB) + s / 2) / s;
    f1 = (sine_fx(tw) * (64'sd1 <<< FB) + s / 2) / s;
    r.deg = 1'b0;
    for (int i = 0; i < 3; i++) begin
      v = a[i] * (f0 >>> FB) + b[i] * (f1 >>> FB) +
          ((a[i] * (f0 & 65535) + b[i] * (f1 & 65535) + (64'sd1 <<< (FB - 1))) >>> FB);
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647; r.sat = 1'b1;
      end else if (v < -64'sd2147483648) begin
        v = -64'sd2147483648; r.sat = 1'b1;
      end
      case (i)
        0: r.x = comp_t'(v);
        1: r.y = comp_t'(v);
        default: r.z = comp_t'(v);
      endcase
    end
    return r;
  endfunction

  // ---------------- sender ----------------

  task automatic send_vectors(comp_t a [3], comp_t b [3], logic [16:0] frac,
                              bit typed, slerp_res_t typed_res);
    slerp_res_t want;
    want = typed ? typed_res : slerp_predict(a, b, frac);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, frac, b[2], b[1], b[0], a[2], a[1], a[0]};
    do @(posedge clk); while (!s_tready);
    pending_q = {pending_q, want};
  endtask

  // random component: random bits over a random magnitude, now and then zero
  function automatic comp_t rand_comp();
    if ($urandom_range(15) == 0) return '0;
    return comp_t'($signed($urandom) >>> $urandom_range(31));
  endfunction

  task automatic send_random();
    comp_t a [3], b [3];
    logic [16:0] frac;
    int kind, sh;
    slerp_res_t none;
    none = '{x: 0, y: 0, z: 0, deg: 1'b0, sat: 1'b0};
    kind = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      a[i] = rand_comp();
      b[i] = rand_comp();
    end
    if (kind < 5) begin
      // b from a, scaled, each component with a random sign
      sh = $urandom_range(3);
      for (int i = 0; i < 3; i++) b[i] = ($urandom_range(1) ? a[i] : -a[i]) >>> sh;
    end else if (kind < 10) begin
      // b a small nudge away from a
      for (int i = 0; i < 3; i++) b[i] = a[i] + comp_t'($urandom_range(7)) - 3;
    end else if (kind < 13) begin
      a = '{0, 0, 0};
    end
    if ($urandom_range(9) == 0) frac = 17'($urandom);
    else frac = 17'($urandom_range(65536));
    send_vectors(a, b, frac, 1'b0, none);
  endtask

  task automatic drain_and_pause();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // ---------------- receiver and checker ----------------

  always @(posedge clk) begin
    if (rx_hold_cnt > 0) rx_hold_cnt <= rx_hold_cnt - 1;
  end

  initial begin
    slerp_res_t want;
    comp_t got_x, got_y, got_z;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got_x = m_tdata[31:0];
        got_y = m_tdata[63:32];
        got_z = m_tdata[95:64];
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: %h %b", m_tdata, m_tuser);
        end else begin
          want = pending_q.pop_front();
          if (got_x !== want.x || got_y !== want.y || got_z !== want.z ||
              m_tuser[0] !== want.deg || m_tuser[1] !== want.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d %0d %0d deg=%b sat=%b, got %0d %0d %0d deg=%b sat=%b",
                       want.x, want.y, want.z, want.deg, want.sat,
                       got_x, got_y, got_z, m_tuser[0], m_tuser[1]);
          end
        end
      end
      m_tready <= (rx_hold_cnt == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------- stimulus ----------------

  localparam comp_t ONE = 32'sh10000;
  localparam comp_t MAXC = 32'sh7FFFFFFF;
  localparam comp_t MINC = -32'sh80000000;

  slerp_row_t dir_rows [] = '{
    // null vectors, parallel and opposite pairs: zero result, degenerate set
    '{'{0, 0, 0}, '{0, 0, 0}, 17'd0, 1, '{0, 0, 0, 1, 0}},
    '{'{0, 0, 0}, '{ONE, 2, -3}, 17'd32768, 1, '{0, 0, 0, 1, 0}},
    '{'{MAXC, MINC, 1}, '{0, 0, 0}, 17'd65536, 1, '{0, 0, 0, 1, 0}},
    '{'{ONE, 0, 0}, '{ONE, 0, 0}, 17'd16384, 1, '{0, 0, 0, 1, 0}},
    '{'{ONE, 0, 0}, '{-2*ONE, 0, 0}, 17'd32768, 1, '{0, 0, 0, 1, 0}},
    '{'{MAXC, MAXC, MAXC}, '{MAXC, MAXC, MAXC}, 17'd1, 1, '{0, 0, 0, 1, 0}},
    // orthogonal unit vectors across the fraction range, incl. above one
    '{'{ONE, 0, 0}, '{0, ONE, 0}, 17'd0, 0, '{0, 0, 0, 0, 0}},
    '{'{ONE, 0, 0}, '{0, ONE, 0}, 17'd32768, 0, '{0, 0, 0, 0, 0}},
    '{'{ONE, 0, 0}, '{0, ONE, 0}, 17'd65536, 0, '{0, 0, 0, 0, 0}},
    '{'{ONE, 0, 0}, '{0, ONE, 0}, 17'h1FFFF, 0, '{0, 0, 0, 0, 0}},
    '{'{0, 0, ONE}, '{0, -ONE, 0}, 17'd65537, 0, '{0, 0, 0, 0, 0}},
    // extreme components
    '{'{MAXC, 0, 0}, '{0, MAXC, 0}, 17'd32768, 0, '{0, 0, 0, 0, 0}},
    '{'{MINC, MINC, 0}, '{0, MINC, MINC}, 17'd12345, 0, '{0, 0, 0, 0, 0}},
    '{'{MAXC, MINC, MAXC}, '{MINC, MAXC, 5}, 17'd50000, 0, '{0, 0, 0, 0, 0}},
    '{'{1, 0, 0}, '{0, 0, -1}, 17'd32768, 0, '{0, 0, 0, 0, 0}},
    // nearly parallel: large factors, may saturate
    '{'{32'sh40000000, 0, 0}, '{32'sh40000000, 1, 0}, 17'd32768, 0, '{0, 0, 0, 0, 0}},
    '{'{MAXC, 0, 0}, '{MAXC, 32'sh100, 0}, 17'd65535, 0, '{0, 0, 0, 0, 0}},
    '{'{ONE, ONE, 0}, '{-ONE, -ONE, 3}, 17'd20000, 0, '{0, 0, 0, 0, 0}},
    '{'{-3*ONE, 7, 2*ONE}, '{ONE, -5*ONE, 9}, 17'd40000, 0, '{0, 0, 0, 0, 0}}
  };

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_vectors(dir_rows[i].a, dir_rows[i].b, dir_rows[i].frac,
                   dir_rows[i].typed, dir_rows[i].res);
    drain_and_pause();

    // phase one: sender rarely idles, receiver often does; one long hold-off
    for (int n = 0; n < 385; n++) begin
      if (n == 60) rx_hold_cnt = RX_HOLD;
      send_random();
    end
    drain_and_pause();

    tx_idle_pct = 74;
    rx_idle_pct = 18;
    for (int n = 0; n < 385; n++) send_random();
    drain_and_pause();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int n = 0; n < 385; n++) send_random();
    s_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
